### rtl/mie_pkg.sv
package mie_pkg;

   typedef enum logic [3:0] {
      MEM_NONE = 4'd0,
      MEM_LB   = 4'd1,
      MEM_LBU  = 4'd2,
      MEM_LH   = 4'd3,
      MEM_LHU  = 4'd4,
      MEM_LW   = 4'd5,
      MEM_SB   = 4'd6,
      MEM_SH   = 4'd7,
      MEM_SW   = 4'd8
   } mem_kind_type;

   typedef enum logic [2:0] {
      EXC_NONE     = 3'd0,
      EXC_OVERFLOW = 3'd1,
      EXC_SYSCALL  = 3'd2,
      EXC_BREAK    = 3'd3,
      EXC_UNKNOWN  = 3'd4
   } exc_code_type;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] FN_MULT    = 6'h18;
   localparam logic [5:0] FN_MULTU   = 6'h19;
   localparam logic [5:0] FN_DIV     = 6'h1a;
   localparam logic [5:0] FN_DIVU    = 6'h1b;

   // controller -> datapath
   typedef struct packed {
      logic load_in;
      logic mul_start;
      logic div_start;
      logic div_step;
      logic rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_mul;
      logic is_div;
      logic div_last;
   } status_type;

endpackage

### rtl/mie_datapath.sv
module mie_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  mie_pkg::cmd_type       cmd,
   output mie_pkg::status_type    status,
   input  logic                   cache_isolated,
   input  logic [31:0]            instr_word,
   input  logic [31:0]            next_pc,
   input  logic [31:0]            src_a_value,
   input  logic [31:0]            src_b_value,
   input  logic                   in_delay_slot,
   output logic [4:0]             dest_index,
   output logic [31:0]            dest_value,
   output logic                   dest_write,
   output logic                   branch_taken,
   output logic [31:0]            branch_target,
   output logic [3:0]             mem_kind,
   output logic [31:0]            mem_address,
   output logic [31:0]            store_data,
   output logic [2:0]             exception_code,
   output logic                   exc_in_delay_slot
);

   logic [31:0] iw_ff, npc_ff, a_ff, b_ff;
   logic        ds_ff;
   logic [31:0] hi_ff, hi_in, lo_ff, lo_in;
   // divider
   logic [31:0] quo_ff, rem_ff, dvs_ff;
   logic [4:0]  cnt_ff;
   logic        negq_ff, negr_ff, dspec_ff;
   logic [31:0] spec_hi_ff, spec_lo_ff;
   // multiplier: 32x16 partial products accumulated over steps
   logic [63:0] prod_ff;
   logic [31:0] ma_ff, mb_ff;
   logic        negp_ff;
   logic [1:0]  mcnt_ff;

   logic [5:0]  op, fn;
   logic [4:0]  rt, rd, sh;
   logic [15:0] imm;
   logic [31:0] simm, btgt, npc4;

   assign op   = iw_ff[31:26];
   assign rt   = iw_ff[20:16];
   assign rd   = iw_ff[15:11];
   assign sh   = iw_ff[10:6];
   assign fn   = iw_ff[5:0];
   assign imm  = iw_ff[15:0];
   assign simm = {{16{imm[15]}}, imm};
   assign btgt = npc_ff + {simm[29:0], 2'b00};
   assign npc4 = npc_ff + 32'd4;

   assign status.is_mul   = (op == mie_pkg::OP_SPECIAL) &&
                            (fn == mie_pkg::FN_MULT || fn == mie_pkg::FN_MULTU);
   assign status.is_div   = (op == mie_pkg::OP_SPECIAL) &&
                            (fn == mie_pkg::FN_DIV || fn == mie_pkg::FN_DIVU);
   assign status.div_last = dspec_ff ? 1'b1 : (cnt_ff == 5'd31 && mcnt_ff == 2'd3) ||
                            (status.is_div ? cnt_ff == 5'd31 : mcnt_ff == 2'd3);

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         iw_ff  <= instr_word;
         npc_ff <= next_pc;
         a_ff   <= src_a_value;
         b_ff   <= src_b_value;
         ds_ff  <= in_delay_slot;
      end
   end

   // shared setup values
   logic sgn, na, nb;
   logic [31:0] mag_a, mag_b;
   assign sgn   = (fn == mie_pkg::FN_DIV) || (fn == mie_pkg::FN_MULT);
   assign na    = sgn & a_ff[31];
   assign nb    = sgn & b_ff[31];
   assign mag_a = na ? 32'd0 - a_ff : a_ff;
   assign mag_b = nb ? 32'd0 - b_ff : b_ff;

   // restoring divide, one bit per cycle
   logic [32:0] trial;
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};

   // multiply: two 32x16 partial products, low half then high half, counter on mcnt
   logic [47:0] pp;
   assign pp = ma_ff * {16'd0, mb_ff[15:0]};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff   <= mag_a;
         rem_ff   <= '0;
         dvs_ff   <= mag_b;
         cnt_ff   <= '0;
         negq_ff  <= na ^ nb;
         negr_ff  <= na;
         dspec_ff <= (b_ff == 32'd0) ||
                     (fn == mie_pkg::FN_DIV && a_ff == 32'h8000_0000 && b_ff == 32'hffff_ffff);
         spec_hi_ff <= (b_ff == 32'd0) ? a_ff : 32'd0;
         spec_lo_ff <= (b_ff != 32'd0) ? 32'h8000_0000 :
                       ((fn == mie_pkg::FN_DIV && a_ff[31]) ? 32'd1 : 32'hffff_ffff);
         mcnt_ff  <= 2'd0;
      end else if (cmd.div_step && status.is_div) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], quo_ff[31]};
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (cmd.mul_start) begin
         ma_ff    <= mag_a;
         mb_ff    <= mag_b;
         negp_ff  <= na ^ nb;
         prod_ff  <= '0;
         mcnt_ff  <= 2'd0;
         dspec_ff <= 1'b0;
         cnt_ff   <= '0;
      end else if (cmd.div_step && status.is_mul) begin
         mcnt_ff <= mcnt_ff + 2'd1;
         if (mcnt_ff == 2'd0) prod_ff <= {16'd0, pp};
         else if (mcnt_ff == 2'd1) mb_ff <= {16'd0, mb_ff[31:16]};
         else if (mcnt_ff == 2'd2) prod_ff <= prod_ff + {pp, 16'd0};
         else if (negp_ff) prod_ff <= 64'd0 - prod_ff;
      end
   end

   // writeback logic
   logic [31:0] dv, tgt, maddr, sd, t;
   logic [4:0]  di;
   logic        dw, bt;
   logic [3:0]  mk;
   logic [2:0]  exc;

   always_comb begin
      hi_in = hi_ff;
      lo_in = lo_ff;
      di = '0; dv = '0; dw = 1'b0; bt = 1'b0; tgt = '0;
      mk = mie_pkg::MEM_NONE; maddr = '0; sd = '0; exc = mie_pkg::EXC_NONE;
      t  = '0;
      if (op == mie_pkg::OP_SPECIAL) begin
         case (fn)
            6'h00: begin di = rd; dv = b_ff << sh; dw = 1'b1; end
            6'h02: begin di = rd; dv = b_ff >> sh; dw = 1'b1; end
            6'h03: begin di = rd; dv = $signed(b_ff) >>> sh; dw = 1'b1; end
            6'h04: begin di = rd; dv = b_ff << a_ff[4:0]; dw = 1'b1; end
            6'h06: begin di = rd; dv = b_ff >> a_ff[4:0]; dw = 1'b1; end
            6'h07: begin di = rd; dv = $signed(b_ff) >>> a_ff[4:0]; dw = 1'b1; end
            6'h08: begin tgt = a_ff; bt = 1'b1; end
            6'h09: begin tgt = a_ff; bt = 1'b1; di = rd; dv = npc4; dw = 1'b1; end
            6'h0c: exc = mie_pkg::EXC_SYSCALL;
            6'h0d: exc = mie_pkg::EXC_BREAK;
            6'h10: begin di = rd; dv = hi_ff; dw = 1'b1; end
            6'h11: hi_in = a_ff;
            6'h12: begin di = rd; dv = lo_ff; dw = 1'b1; end
            6'h13: lo_in = a_ff;
            mie_pkg::FN_MULT, mie_pkg::FN_MULTU: begin
               lo_in = prod_ff[31:0];
               hi_in = prod_ff[63:32];
            end
            mie_pkg::FN_DIV, mie_pkg::FN_DIVU: begin
               if (dspec_ff) begin
                  lo_in = spec_lo_ff;
                  hi_in = spec_hi_ff;
               end else begin
                  lo_in = negq_ff ? 32'd0 - quo_ff : quo_ff;
                  hi_in = negr_ff ? 32'd0 - rem_ff : rem_ff;
               end
            end
            6'h20: begin
               t = a_ff + b_ff;
               if (~(a_ff[31] ^ b_ff[31]) & (a_ff[31] ^ t[31])) exc = mie_pkg::EXC_OVERFLOW;
               else begin di = rd; dv = t; dw = 1'b1; end
            end
            6'h21: begin di = rd; dv = a_ff + b_ff; dw = 1'b1; end
            6'h22: begin
               t = a_ff - b_ff;
               if ((a_ff[31] ^ b_ff[31]) & (a_ff[31] ^ t[31])) exc = mie_pkg::EXC_OVERFLOW;
               else begin di = rd; dv = t; dw = 1'b1; end
            end
            6'h23: begin di = rd; dv = a_ff - b_ff; dw = 1'b1; end
            6'h24: begin di = rd; dv = a_ff & b_ff; dw = 1'b1; end
            6'h25: begin di = rd; dv = a_ff | b_ff; dw = 1'b1; end
            6'h26: begin di = rd; dv = a_ff ^ b_ff; dw = 1'b1; end
            6'h27: begin di = rd; dv = ~(a_ff | b_ff); dw = 1'b1; end
            6'h2a: begin
               di = rd; dw = 1'b1;
               dv = {31'd0, $signed(a_ff) < $signed(b_ff)};
            end
            6'h2b: begin di = rd; dv = {31'd0, a_ff < b_ff}; dw = 1'b1; end
            default: exc = mie_pkg::EXC_UNKNOWN;
         endcase
      end else begin
         case (op)
            mie_pkg::OP_REGIMM: begin
               case (rt)
                  5'h00: begin tgt = btgt; bt = a_ff[31]; end
                  5'h01: begin tgt = btgt; bt = ~a_ff[31]; end
                  5'h10: begin tgt = btgt; bt = a_ff[31]; di = 5'd31; dv = npc4; dw = 1'b1; end
                  5'h11: begin tgt = btgt; bt = ~a_ff[31]; di = 5'd31; dv = npc4; dw = 1'b1; end
                  default: ;
               endcase
            end
            6'h02, 6'h03: begin
               tgt = {npc_ff[31:28], iw_ff[25:0], 2'b00};
               bt  = 1'b1;
               if (op == 6'h03) begin di = 5'd31; dv = npc4; dw = 1'b1; end
            end
            6'h04: begin tgt = btgt; bt = a_ff == b_ff; end
            6'h05: begin tgt = btgt; bt = a_ff != b_ff; end
            6'h06: begin tgt = btgt; bt = a_ff[31] || a_ff == 32'd0; end
            6'h07: begin tgt = btgt; bt = !a_ff[31] && a_ff != 32'd0; end
            6'h08: begin
               t = a_ff + simm;
               if (~(a_ff[31] ^ simm[31]) & (a_ff[31] ^ t[31])) exc = mie_pkg::EXC_OVERFLOW;
               else begin di = rt; dv = t; dw = 1'b1; end
            end
            6'h09: begin di = rt; dv = a_ff + simm; dw = 1'b1; end
            6'h0a: begin di = rt; dv = {31'd0, $signed(a_ff) < $signed(simm)}; dw = 1'b1; end
            6'h0b: begin di = rt; dv = {31'd0, a_ff < simm}; dw = 1'b1; end
            6'h0c: begin di = rt; dv = a_ff & {16'd0, imm}; dw = 1'b1; end
            6'h0d: begin di = rt; dv = a_ff | {16'd0, imm}; dw = 1'b1; end
            6'h0e: begin di = rt; dv = a_ff ^ {16'd0, imm}; dw = 1'b1; end
            6'h0f: begin di = rt; dv = {imm, 16'd0}; dw = 1'b1; end
            6'h20: mk = mie_pkg::MEM_LB;
            6'h24: mk = mie_pkg::MEM_LBU;
            6'h21: mk = mie_pkg::MEM_LH;
            6'h25: mk = mie_pkg::MEM_LHU;
            6'h23: mk = cache_isolated ? mie_pkg::MEM_NONE : mie_pkg::MEM_LW;
            6'h28: mk = cache_isolated ? mie_pkg::MEM_NONE : mie_pkg::MEM_SB;
            6'h29: mk = cache_isolated ? mie_pkg::MEM_NONE : mie_pkg::MEM_SH;
            6'h2b: mk = cache_isolated ? mie_pkg::MEM_NONE : mie_pkg::MEM_SW;
            6'h10, 6'h11, 6'h12, 6'h13, 6'h30, 6'h31, 6'h32, 6'h33,
            6'h38, 6'h39, 6'h3a, 6'h3b, 6'h22, 6'h26, 6'h2a, 6'h2e: ;
            default: exc = mie_pkg::EXC_UNKNOWN;
         endcase
         if (mk != mie_pkg::MEM_NONE) begin
            maddr = a_ff + simm;
            if (mk >= mie_pkg::MEM_SB) sd = b_ff;
            else di = rt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff <= '0;
         lo_ff <= '0;
      end else if (cmd.rsp_load) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         dest_index        <= di;
         dest_value        <= dv;
         dest_write        <= dw;
         branch_taken      <= bt;
         branch_target     <= tgt;
         mem_kind          <= mk;
         mem_address       <= maddr;
         store_data        <= sd;
         exception_code    <= exc;
         exc_in_delay_slot <= (exc != mie_pkg::EXC_NONE) ? ds_ff : 1'b0;
      end
   end

endmodule

### rtl/mie_control.sv
module mie_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  mie_pkg::status_type status,
   output mie_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_ITER  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // a finished result may wait in the output register while the next
   // transaction is being taken in
   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_ITER;
            end else if (status.is_mul) begin
               cmd.mul_start = 1'b1;
               state_in      = ST_ITER;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ITER: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !rsp_valid_ff || rsp_ready)
      else $error("result register overwritten");
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_EXEC)
      else $error("transaction not started");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state not one-hot");

endmodule

### rtl/mips1_integer_execute.sv
// MIPS I integer execute unit.
// req_ channel: one transaction per instruction (word, next pc, rs/rt values,
// delay-slot flag). rsp_ channel: one result transaction per instruction with
// writeback, branch decision, memory request and exception code.
// csr_ channel: writes the cache_isolated bit; write only while idle.
// ALU, branch and memory ops go from the exec state to the done state; rsp_valid rises
// when the result register is loaded. mult/multu use a 32x16 multiplier over
// 4 steps; div/divu use a restoring divider that resolves one quotient bit per
// cycle. Divide by zero and the most-negative-over-minus-one case end on the
// first iteration step with a special-case result.
// One instruction is in flight at a time; the result register holds a
// finished result while the next transaction is taken in and executed.
// If the receiver stalls, the next result waits until rsp_ready.
// Reset clears hi, lo, cache_isolated and all handshake state.
module mips1_integer_execute (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_next_pc,
   input  logic [31:0] req_src_a_value,
   input  logic [31:0] req_src_b_value,
   input  logic        req_in_delay_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_dest_value,
   output logic        rsp_dest_write,
   output logic        rsp_branch_taken,
   output logic [31:0] rsp_branch_target,
   output logic [3:0]  rsp_mem_kind,
   output logic [31:0] rsp_mem_address,
   output logic [31:0] rsp_store_data,
   output logic [2:0]  rsp_exception_code,
   output logic        rsp_exc_in_delay_slot,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_cache_isolated
);

   mie_pkg::cmd_type    cmd;
   mie_pkg::status_type status;
   logic                cache_iso_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) cache_iso_ff <= 1'b0;
      else if (csr_valid) cache_iso_ff <= csr_cache_isolated;
   end

   mie_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mie_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .cache_isolated    (cache_iso_ff),
      .instr_word        (req_instr_word),
      .next_pc           (req_next_pc),
      .src_a_value       (req_src_a_value),
      .src_b_value       (req_src_b_value),
      .in_delay_slot     (req_in_delay_slot),
      .dest_index        (rsp_dest_index),
      .dest_value        (rsp_dest_value),
      .dest_write        (rsp_dest_write),
      .branch_taken      (rsp_branch_taken),
      .branch_target     (rsp_branch_target),
      .mem_kind          (rsp_mem_kind),
      .mem_address       (rsp_mem_address),
      .store_data        (rsp_store_data),
      .exception_code    (rsp_exception_code),
      .exc_in_delay_slot (rsp_exc_in_delay_slot)
   );

endmodule

### sim/mips1_integer_execute_check.sv
module mips1_integer_execute_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_next_pc,
   input  logic [31:0] req_src_a_value,
   input  logic [31:0] req_src_b_value,
   input  logic        req_in_delay_slot,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [4:0]  rsp_dest_index,
   input  logic [31:0] rsp_dest_value,
   input  logic        rsp_dest_write,
   input  logic        rsp_branch_taken,
   input  logic [31:0] rsp_branch_target,
   input  logic [3:0]  rsp_mem_kind,
   input  logic [31:0] rsp_mem_address,
   input  logic [31:0] rsp_store_data,
   input  logic [2:0]  rsp_exception_code,
   input  logic        rsp_exc_in_delay_slot,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_cache_isolated,
   output int          error_count,
   output int          pending_count
);

   typedef struct packed {
      logic [4:0]            dest_index;
      logic [31:0]           dest_value;
      logic                  dest_write;
      logic                  branch_taken;
      logic [31:0]           branch_target;
      mie_pkg::mem_kind_type mem_kind;
      logic [31:0]           mem_address;
      logic [31:0]           store_data;
      mie_pkg::exc_code_type exc_code;
      logic                  exc_slot;
   } exec_result_type;

   exec_result_type expected_results[$];
   logic [31:0]     hi_model, lo_model;
   logic            isolated_model;

   function automatic logic signed_less(logic [31:0] x, logic [31:0] y);
      return $signed(x) < $signed(y);
   endfunction

   task automatic divide_signed(input logic [31:0] x, input logic [31:0] y);
      logic [31:0] mx, my, q, r;
      if (y == 32'd0) begin
         lo_model = x[31] ? 32'd1 : 32'hffffffff;
         hi_model = x;
      end else if (x == 32'h80000000 && y == 32'hffffffff) begin
         lo_model = 32'h80000000;
         hi_model = 32'd0;
      end else begin
         mx = x[31] ? -x : x;
         my = y[31] ? -y : y;
         q = mx / my;
         r = mx % my;
         lo_model = (x[31] != y[31]) ? -q : q;
         hi_model = x[31] ? -r : r;
      end
   endtask

   task automatic execute_instr(input logic [31:0] iw, input logic [31:0] npc,
                                input logic [31:0] a, input logic [31:0] b,
                                input logic ds, output exec_result_type res);
      logic [5:0]  op, fn;
      logic [4:0]  rt, rd, sh;
      logic [31:0] imm, simm, btgt, t;
      logic [63:0] p;
      op = iw[31:26];
      rt = iw[20:16];
      rd = iw[15:11];
      sh = iw[10:6];
      fn = iw[5:0];
      imm = {16'd0, iw[15:0]};
      simm = {{16{iw[15]}}, iw[15:0]};
      btgt = npc + (simm << 2);
      res = '0;
      if (op == mie_pkg::OP_SPECIAL) begin
         case (fn)
            6'h00: begin res.dest_index = rd; res.dest_value = b << sh; res.dest_write = 1; end
            6'h02: begin res.dest_index = rd; res.dest_value = b >> sh; res.dest_write = 1; end
            6'h03: begin res.dest_index = rd; res.dest_value = $signed(b) >>> sh;
               res.dest_write = 1; end
            6'h04: begin res.dest_index = rd; res.dest_value = b << a[4:0];
               res.dest_write = 1; end
            6'h06: begin res.dest_index = rd; res.dest_value = b >> a[4:0];
               res.dest_write = 1; end
            6'h07: begin res.dest_index = rd; res.dest_value = $signed(b) >>> a[4:0];
               res.dest_write = 1; end
            6'h08: begin res.branch_target = a; res.branch_taken = 1; end
            6'h09: begin res.branch_target = a; res.branch_taken = 1;
               res.dest_index = rd; res.dest_value = npc + 32'd4; res.dest_write = 1; end
            6'h0c: res.exc_code = mie_pkg::EXC_SYSCALL;
            6'h0d: res.exc_code = mie_pkg::EXC_BREAK;
            6'h10: begin res.dest_index = rd; res.dest_value = hi_model; res.dest_write = 1; end
            6'h11: hi_model = a;
            6'h12: begin res.dest_index = rd; res.dest_value = lo_model; res.dest_write = 1; end
            6'h13: lo_model = a;
            mie_pkg::FN_MULT: begin
               p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
               {hi_model, lo_model} = p;
            end
            mie_pkg::FN_MULTU: begin
               p = {32'd0, a} * {32'd0, b};
               {hi_model, lo_model} = p;
            end
            mie_pkg::FN_DIV: divide_signed(a, b);
            mie_pkg::FN_DIVU: begin
               if (b == 32'd0) begin lo_model = 32'hffffffff; hi_model = a; end
               else begin lo_model = a / b; hi_model = a % b; end
            end
            6'h20: begin
               t = a + b;
               if (a[31] == b[31] && t[31] != a[31]) res.exc_code = mie_pkg::EXC_OVERFLOW;
               else begin res.dest_index = rd; res.dest_value = t; res.dest_write = 1; end
            end
            6'h21: begin res.dest_index = rd; res.dest_value = a + b; res.dest_write = 1; end
            6'h22: begin
               t = a - b;
               if (a[31] != b[31] && t[31] != a[31]) res.exc_code = mie_pkg::EXC_OVERFLOW;
               else begin res.dest_index = rd; res.dest_value = t; res.dest_write = 1; end
            end
            6'h23: begin res.dest_index = rd; res.dest_value = a - b; res.dest_write = 1; end
            6'h24: begin res.dest_index = rd; res.dest_value = a & b; res.dest_write = 1; end
            6'h25: begin res.dest_index = rd; res.dest_value = a | b; res.dest_write = 1; end
            6'h26: begin res.dest_index = rd; res.dest_value = a ^ b; res.dest_write = 1; end
            6'h27: begin res.dest_index = rd; res.dest_value = ~(a | b); res.dest_write = 1; end
            6'h2a: begin res.dest_index = rd; res.dest_value = {31'd0, signed_less(a, b)};
               res.dest_write = 1; end
            6'h2b: begin res.dest_index = rd; res.dest_value = {31'd0, a < b};
               res.dest_write = 1; end
            default: res.exc_code = mie_pkg::EXC_UNKNOWN;
         endcase
      end else begin
         case (op)
            mie_pkg::OP_REGIMM: begin
               if (rt == 5'h00 || rt == 5'h10) begin
                  res.branch_target = btgt; res.branch_taken = a[31];
               end else if (rt == 5'h01 || rt == 5'h11) begin
                  res.branch_target = btgt; res.branch_taken = !a[31];
               end
               if (rt == 5'h10 || rt == 5'h11) begin
                  res.dest_index = 5'd31; res.dest_value = npc + 32'd4; res.dest_write = 1;
               end
            end
            6'h02, 6'h03: begin
               res.branch_target = {npc[31:28], iw[25:0], 2'b00};
               res.branch_taken = 1;
               if (op == 6'h03) begin
                  res.dest_index = 5'd31; res.dest_value = npc + 32'd4; res.dest_write = 1;
               end
            end
            6'h04: begin res.branch_target = btgt; res.branch_taken = a == b; end
            6'h05: begin res.branch_target = btgt; res.branch_taken = a != b; end
            6'h06: begin res.branch_target = btgt; res.branch_taken = a[31] || a == 0; end
            6'h07: begin res.branch_target = btgt; res.branch_taken = !a[31] && a != 0; end
            6'h08: begin
               t = a + simm;
               if (a[31] == simm[31] && t[31] != a[31]) res.exc_code = mie_pkg::EXC_OVERFLOW;
               else begin res.dest_index = rt; res.dest_value = t; res.dest_write = 1; end
            end
            6'h09: begin res.dest_index = rt; res.dest_value = a + simm; res.dest_write = 1; end
            6'h0a: begin res.dest_index = rt; res.dest_value = {31'd0, signed_less(a, simm)};
               res.dest_write = 1; end
            6'h0b: begin res.dest_index = rt; res.dest_value = {31'd0, a < simm};
               res.dest_write = 1; end
            6'h0c: begin res.dest_index = rt; res.dest_value = a & imm; res.dest_write = 1; end
            6'h0d: begin res.dest_index = rt; res.dest_value = a | imm; res.dest_write = 1; end
            6'h0e: begin res.dest_index = rt; res.dest_value = a ^ imm; res.dest_write = 1; end
            6'h0f: begin res.dest_index = rt; res.dest_value = imm << 16; res.dest_write = 1; end
            6'h20: res.mem_kind = mie_pkg::MEM_LB;
            6'h24: res.mem_kind = mie_pkg::MEM_LBU;
            6'h21: res.mem_kind = mie_pkg::MEM_LH;
            6'h25: res.mem_kind = mie_pkg::MEM_LHU;
            6'h23: res.mem_kind = isolated_model ? mie_pkg::MEM_NONE : mie_pkg::MEM_LW;
            6'h28: res.mem_kind = isolated_model ? mie_pkg::MEM_NONE : mie_pkg::MEM_SB;
            6'h29: res.mem_kind = isolated_model ? mie_pkg::MEM_NONE : mie_pkg::MEM_SH;
            6'h2b: res.mem_kind = isolated_model ? mie_pkg::MEM_NONE : mie_pkg::MEM_SW;
            6'h10, 6'h11, 6'h12, 6'h13, 6'h30, 6'h31, 6'h32, 6'h33,
            6'h38, 6'h39, 6'h3a, 6'h3b, 6'h22, 6'h26, 6'h2a, 6'h2e: ;
            default: res.exc_code = mie_pkg::EXC_UNKNOWN;
         endcase
         if (res.mem_kind != mie_pkg::MEM_NONE) begin
            res.mem_address = a + simm;
            if (res.mem_kind >= mie_pkg::MEM_SB) res.store_data = b;
            else res.dest_index = rt;
         end
      end
      if (res.exc_code != mie_pkg::EXC_NONE) res.exc_slot = ds;
   endtask

   exec_result_type seen, want;

   always @(posedge clock) begin
      if (reset) begin
         hi_model = 32'd0;
         lo_model = 32'd0;
         isolated_model = 1'b0;
         expected_results.delete();
         error_count <= 0;
      end else begin
         if (csr_valid && csr_ready) isolated_model = csr_cache_isolated;
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_dest_index, rsp_dest_value, rsp_dest_write, rsp_branch_taken,
                    rsp_branch_target, mie_pkg::mem_kind_type'(rsp_mem_kind),
                    rsp_mem_address, rsp_store_data,
                    mie_pkg::exc_code_type'(rsp_exception_code), rsp_exc_in_delay_slot};
            if (expected_results.size() == 0) begin
               if (error_count < 10) $display("unexpected result transaction %h", seen);
               error_count <= error_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (seen !== want) begin
                  if (error_count < 10)
                     $display("mismatch: expected %p actual %p", want, seen);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            execute_instr(req_instr_word, req_next_pc, req_src_a_value, req_src_b_value,
                          req_in_delay_slot, want);
            expected_results.push_back(want);
         end
      end
      pending_count = expected_results.size();
   end

endmodule

### sim/mips1_integer_execute_test.sv
module mips1_integer_execute_test;

   logic        clock = 0, reset = 1;
   logic        req_valid = 0, req_ready;
   logic [31:0] req_instr_word = 0, req_next_pc = 0, req_src_a_value = 0;
   logic [31:0] req_src_b_value = 0;
   logic        req_in_delay_slot = 0;
   logic        rsp_valid, rsp_ready = 0;
   logic [4:0]  rsp_dest_index;
   logic [31:0] rsp_dest_value, rsp_branch_target, rsp_mem_address, rsp_store_data;
   logic        rsp_dest_write, rsp_branch_taken, rsp_exc_in_delay_slot;
   logic [3:0]  rsp_mem_kind;
   logic [2:0]  rsp_exception_code;
   logic        csr_valid = 0, csr_ready, csr_cache_isolated = 0;
   int          error_count, pending_count, idle_cycles;
   bit          hold_results;

   always #2 clock = ~clock;

   mips1_integer_execute uut (.*);
   mips1_integer_execute_check checker_inst (.*);

   localparam logic [5:0] OPCODES [30] = '{6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h05, 6'h06,
      6'h07, 6'h08, 6'h09, 6'h0a, 6'h0b, 6'h0c, 6'h0d, 6'h0e, 6'h0f, 6'h20, 6'h21, 6'h23,
      6'h24, 6'h25, 6'h28, 6'h29, 6'h2b, 6'h10, 6'h22, 6'h2e, 6'h3b, 6'h3f, 6'h17};
   localparam logic [5:0] FUNCTS [30] = '{6'h00, 6'h02, 6'h03, 6'h04, 6'h06, 6'h07, 6'h08,
      6'h09, 6'h0c, 6'h0d, 6'h10, 6'h11, 6'h12, 6'h13, mie_pkg::FN_MULT, mie_pkg::FN_MULTU,
      mie_pkg::FN_DIV, mie_pkg::FN_DIVU,
      6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27, 6'h2a, 6'h2b, 6'h01, 6'h3f};
   localparam logic [31:0] EDGES [7] = '{32'h0, 32'h1, 32'h7fffffff, 32'h80000000,
      32'hffffffff, 32'hfffffffe, 32'h00008000};

   function automatic logic [31:0] random_operand();
      if ($urandom_range(0, 3) == 0) return EDGES[$urandom_range(0, 6)];
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 40) - 20;
      return $urandom;
   endfunction

   task automatic gap();
      int n;
      n = $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if ($urandom_range(0, 2) == 0) n = 1;
      repeat (n) @(negedge clock);
   endtask

   // called at a falling edge; req_ready only moves at rising edges
   task automatic send(input logic [31:0] iw, input logic [31:0] a, input logic [31:0] b);
      req_valid <= 1;
      req_instr_word <= iw;
      req_next_pc <= $urandom;
      req_src_a_value <= a;
      req_src_b_value <= b;
      req_in_delay_slot <= 1'($urandom_range(0, 1));
      while (!req_ready) @(negedge clock);
      @(negedge clock);
      req_valid <= 0;
      gap();
   endtask

   task automatic send_random();
      logic [31:0] iw;
      iw = $urandom;
      iw[31:26] = OPCODES[$urandom_range(0, 29)];
      if (iw[31:26] == mie_pkg::OP_SPECIAL) iw[5:0] = FUNCTS[$urandom_range(0, 29)];
      if (iw[31:26] == mie_pkg::OP_REGIMM && $urandom_range(0, 4) != 0)
         iw[20:16] = {1'($urandom_range(0, 1)), 3'b000, 1'($urandom_range(0, 1))};
      send(iw, random_operand(), random_operand());
   endtask

   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_isolated(input logic value);
      drain();
      csr_valid <= 1;
      csr_cache_isolated <= value;
      while (!csr_ready) @(negedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   always @(negedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_results) rsp_ready <= 0;
      else if ($urandom_range(0, 19) == 0) rsp_ready <= 0;
      else if ($urandom_range(0, 3) == 0) rsp_ready <= 1'($urandom_range(0, 1));
      else rsp_ready <= 1;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("mips1_integer_execute_test: done, errors");
         $finish;
      end
   end

   initial begin
      hold_results = 0;
      repeat (9) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed
      send({mie_pkg::OP_SPECIAL, 20'd0, 6'h20}, 32'h7fffffff, 32'h1);
      send({mie_pkg::OP_SPECIAL, 20'd0, 6'h22}, 32'h80000000, 32'h1);
      send({6'h08, 5'd1, 5'd2, 16'h0001}, 32'h7fffffff, 0);
      send({mie_pkg::OP_SPECIAL, 15'h0842, 5'd0, mie_pkg::FN_DIV}, 32'hfffffff9, 0);
      send({mie_pkg::OP_SPECIAL, 15'h0842, 5'd0, mie_pkg::FN_DIV}, 32'h80000000,
           32'hffffffff);
      send({mie_pkg::OP_SPECIAL, 15'h0842, 5'd0, mie_pkg::FN_DIV}, 32'hfffffff9,
           32'hfffffffe);
      send({mie_pkg::OP_SPECIAL, 10'd0, 5'd3, 5'd0, 6'h10}, 0, 0);
      send({mie_pkg::OP_SPECIAL, 10'd0, 5'd4, 5'd0, 6'h12}, 0, 0);
      send({mie_pkg::OP_SPECIAL, 15'h0842, 5'd0, mie_pkg::FN_DIVU}, 32'h12345678, 0);
      send({mie_pkg::OP_SPECIAL, 15'h0842, 5'd0, mie_pkg::FN_MULT}, 32'h80000000,
           32'h80000000);
      send({mie_pkg::OP_SPECIAL, 10'd0, 5'd5, 5'd0, 6'h10}, 0, 0);
      send({mie_pkg::OP_SPECIAL, 15'h0842, 5'd0, mie_pkg::FN_MULTU}, 32'hffffffff,
           32'hffffffff);
      send({mie_pkg::OP_SPECIAL, 10'd0, 5'd6, 5'd0, 6'h12}, 0, 0);
      send({mie_pkg::OP_REGIMM, 5'd1, 5'h10, 16'hffff}, 32'h1, 0);
      send({mie_pkg::OP_REGIMM, 5'd1, 5'h11, 16'h7fff}, 32'h80000000, 0);
      send({6'h0b, 5'd1, 5'd2, 16'hffff}, 32'h5, 0);
      send({6'h23, 5'd1, 5'd2, 16'h8000}, 32'h100, 32'hffffffff);
      send({6'h32, 26'h3ffffff}, 32'hffffffff, 32'hffffffff);
      send({mie_pkg::OP_REGIMM, 5'd1, 5'h05, 16'h1}, 32'h1, 0);
      send({mie_pkg::OP_SPECIAL, 20'hfffff, 6'h0c}, 0, 0);
      send({mie_pkg::OP_SPECIAL, 20'hfffff, 6'h0d}, 0, 0);
      send({mie_pkg::OP_SPECIAL, 20'hfffff, 6'h3f}, 0, 0);
      send({6'h03, 26'h3ffffff}, 0, 0);
      // fill up while the receiver holds off
      hold_results = 1;
      fork
         begin repeat (60) @(negedge clock); hold_results = 0; end
         repeat (8) send_random();
      join
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         write_isolated(phase % 2 == 0);
         for (int i = 0; i < 92; i++) send_random();
      end
      write_isolated(0);
      drain();
      if (error_count == 0) $display("mips1_integer_execute_test: done, clean");
      else $display("mips1_integer_execute_test: done, errors");
      $finish;
   end

endmodule
